/* hw/rtl/pmt_pkg.sv */
// Shared types, constants and lookup tables for the PNA melting temperature block.
package pmt_pkg;

  // Base codes
  localparam logic [2:0] CODE_A    = 3'd0;
  localparam logic [2:0] CODE_C    = 3'd1;
  localparam logic [2:0] CODE_G    = 3'd2;
  localparam logic [2:0] CODE_T    = 3'd3;
  localparam logic [2:0] CODE_NONE = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CONC   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PYR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN    = 3'd4;

  localparam logic signed [11:0] CONC_RESET  = -12'sd300;
  localparam logic [15:0]        SCALE_RESET = 16'd256;

  // Field widths
  localparam int unsigned H_W    = 22;
  localparam int unsigned S_W    = 16;
  localparam int unsigned MT_W   = 17;
  localparam int unsigned CNT_OUT_W = 11;

  // Arithmetic widths
  localparam int unsigned DIV_NUM_W = 33;
  localparam int unsigned DIV_DEN_W = 16;
  localparam int unsigned RAW_W     = 35;
  localparam int unsigned PROD_W    = 52;
  localparam int unsigned SCL_W     = 44;
  localparam int unsigned SUM_W     = 46;

  localparam logic signed [RAW_W-1:0] KELVIN_Q8 = 35'sd69926;
  localparam logic signed [SUM_W-1:0] MT_MIN = -46'sd65536;
  localparam logic signed [SUM_W-1:0] MT_MAX = 46'sd65535;

  // Nearest-neighbor tables, indexed {first, second}
  localparam logic signed [14:0] PAIR_H [16] = '{
    -15'sd8400, -15'sd8600,  -15'sd6100,  -15'sd6500,
    -15'sd7400, -15'sd6700,  -15'sd10100, -15'sd6100,
    -15'sd7700, -15'sd11100, -15'sd6700,  -15'sd8600,
    -15'sd6300, -15'sd7700,  -15'sd7400,  -15'sd8400
  };
  localparam logic signed [9:0] PAIR_S [16] = '{
    -10'sd236, -10'sd230, -10'sd161, -10'sd188,
    -10'sd193, -10'sd156, -10'sd255, -10'sd161,
    -10'sd203, -10'sd284, -10'sd156, -10'sd230,
    -10'sd185, -10'sd203, -10'sd193, -10'sd236
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_START_H,
    ST_WAIT_H,
    ST_START_P,
    ST_WAIT_P,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SCALE,
    ST_ROUND,
    ST_SUM,
    ST_OUT
  } pmt_state_t;

  typedef struct packed {
    logic acc_en;
    logic check;
    logic div_start_h;
    logic div_start_p;
    logic mul_lo;
    logic mul_hi;
    logic scale;
    logic round;
    logic sum;
    logic load_out;
  } pmt_cmd_t;

  typedef struct packed {
    logic skip;
    logic div_busy;
  } pmt_sts_t;

  function automatic logic [2:0] base_code(input logic [7:0] c);
    logic [2:0] code;
    case (c)
      8'h41, 8'h61: code = CODE_A;
      8'h43, 8'h63: code = CODE_C;
      8'h47, 8'h67: code = CODE_G;
      8'h54, 8'h74: code = CODE_T;
      default:      code = CODE_NONE;
    endcase
    return code;
  endfunction

endpackage

/* hw/rtl/pmt_div.sv */
// Restoring divider on unsigned magnitudes, one quotient bit per cycle.
module pmt_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pmt_pkg::DIV_NUM_W-1:0]  num,
  input  logic [pmt_pkg::DIV_DEN_W-1:0]  den,
  output logic [pmt_pkg::DIV_NUM_W-1:0]  quo,
  output logic                           busy
);
  import pmt_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W + 1);

  logic                 busy_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;
  logic [DIV_DEN_W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? DIV_DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIV_NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quo  = quo_r;
  assign busy = busy_r;

endmodule

/* hw/rtl/pmt_dp.sv */
// Datapath: configuration, running sums, Tm arithmetic and result register.
module pmt_dp #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pmt_pkg::pmt_cmd_t               cmd,
  output pmt_pkg::pmt_sts_t               sts,
  input  logic [7:0]                      in_base_char,
  input  logic                            cfg_valid,
  input  logic [pmt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic signed [pmt_pkg::MT_W-1:0] out_melt_temp,
  output logic signed [pmt_pkg::H_W-1:0]  out_enthalpy_total,
  output logic signed [pmt_pkg::S_W-1:0]  out_entropy_total,
  output logic [pmt_pkg::CNT_OUT_W-1:0]   out_pyrimidine_count,
  output logic [pmt_pkg::CNT_OUT_W-1:0]   out_seq_length,
  output logic                            out_too_long,
  output logic                            out_divide_fault
);
  import pmt_pkg::*;

  localparam int unsigned LEN_W   = $clog2(MAX_LEN + 2);
  localparam int unsigned PPROD_W = 16 + LEN_W;
  localparam int unsigned LT_W    = 17 + LEN_W;

  // Configuration
  logic signed [11:0] conc_r;
  logic [15:0]        tm_scale_r;
  logic signed [15:0] tm_offset_r;
  logic signed [15:0] pyr_coeff_r;
  logic signed [15:0] len_coeff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conc_r      <= CONC_RESET;
      tm_scale_r  <= SCALE_RESET;
      tm_offset_r <= '0;
      pyr_coeff_r <= '0;
      len_coeff_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CONC:   conc_r      <= cfg_data[11:0];
        CFG_SCALE:  tm_scale_r  <= cfg_data;
        CFG_OFFSET: tm_offset_r <= cfg_data;
        CFG_PYR:    pyr_coeff_r <= cfg_data;
        CFG_LEN:    len_coeff_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Running sums
  logic [2:0]           prev_r;
  logic signed [H_W-1:0] h_acc_r;
  logic signed [S_W-1:0] s_acc_r;
  logic [LEN_W-1:0]     pyr_acc_r;
  logic [LEN_W-1:0]     len_acc_r;

  logic [2:0]           code;
  logic                 pair_ok;
  logic [3:0]           pidx;
  logic signed [H_W:0]  h_sum;
  logic signed [S_W:0]  s_sum;
  logic                 len_lt;
  logic                 is_pyr;

  always_comb begin
    code    = base_code(in_base_char);
    pair_ok = !prev_r[2] && !code[2];
    pidx    = {prev_r[1:0], code[1:0]};
    h_sum   = (H_W+1)'(h_acc_r) + (H_W+1)'(PAIR_H[pidx]);
    s_sum   = (S_W+1)'(s_acc_r) + (S_W+1)'(PAIR_S[pidx]);
    len_lt  = len_acc_r < LEN_W'(MAX_LEN);
    is_pyr  = (code == CODE_C) || (code == CODE_T);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      prev_r    <= CODE_NONE;
      h_acc_r   <= '0;
      s_acc_r   <= '0;
      pyr_acc_r <= '0;
      len_acc_r <= '0;
    end else if (cmd.acc_en) begin
      if (len_lt) begin
        if (pair_ok) begin
          // sums only fall; a sign flip means underflow, clamp to the floor
          h_acc_r <= (h_sum[H_W] != h_sum[H_W-1]) ? {1'b1, {(H_W-1){1'b0}}}
                                                  : h_sum[H_W-1:0];
          s_acc_r <= (s_sum[S_W] != s_sum[S_W-1]) ? {1'b1, {(S_W-1){1'b0}}}
                                                  : s_sum[S_W-1:0];
        end
        if (is_pyr) begin
          pyr_acc_r <= pyr_acc_r + LEN_W'(1);
        end
        prev_r    <= code;
        len_acc_r <= len_acc_r + LEN_W'(1);
      end else begin
        len_acc_r <= LEN_W'(MAX_LEN + 1);
      end
    end
  end

  // Check stage: divisor, flags, magnitudes
  logic signed [16:0]   denom;
  logic                 d_neg;
  logic                 pc_neg;
  logic [15:0]          pc_mag;
  logic [H_W-1:0]       h_mag;

  logic                 too_long_r;
  logic                 fault_r;
  logic [LEN_W-1:0]     len_fin_r;
  logic [DIV_DEN_W-1:0] dmag_r;
  logic [DIV_NUM_W-1:0] hprod_r;
  logic [PPROD_W-1:0]   pprod_r;
  logic                 neg_h_r;
  logic                 pc_neg_r;

  always_comb begin
    denom  = 17'(s_acc_r) + 17'(conc_r);
    d_neg  = denom[16];
    pc_neg = pyr_coeff_r[15];
    pc_mag = 16'(pc_neg ? -17'(pyr_coeff_r) : 17'(pyr_coeff_r));
    h_mag  = H_W'(-h_acc_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      too_long_r <= len_acc_r > LEN_W'(MAX_LEN);
      fault_r    <= denom == 17'sd0;
      len_fin_r  <= (len_acc_r > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_acc_r;
      dmag_r     <= DIV_DEN_W'(d_neg ? -denom : denom);
      // |H| * 2560 = |H| * 2048 + |H| * 512
      hprod_r    <= (DIV_NUM_W'(h_mag) << 11) + (DIV_NUM_W'(h_mag) << 9);
      pprod_r    <= PPROD_W'(pc_mag) * PPROD_W'(pyr_acc_r);
      neg_h_r    <= h_acc_r[H_W-1] ^ d_neg;
      pc_neg_r   <= pc_neg;
    end
  end

  // Shared divider; numerators carry half the divisor for round to nearest
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] quo;
  logic                 div_busy;

  always_comb begin
    div_start = cmd.div_start_h || cmd.div_start_p;
    if (cmd.div_start_h) begin
      div_num = hprod_r + DIV_NUM_W'(dmag_r[DIV_DEN_W-1:1]);
      div_den = dmag_r;
    end else begin
      div_num = DIV_NUM_W'(pprod_r) + DIV_NUM_W'(len_fin_r[LEN_W-1:1]);
      div_den = DIV_DEN_W'(len_fin_r);
    end
  end

  pmt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .busy  (div_busy)
  );

  // Tm arithmetic
  logic signed [RAW_W-1:0]  raw_r;
  logic signed [RAW_W-1:0]  quo_s;
  logic signed [16:0]       pyr_term_r;
  logic [32:0]              prod_lo_r;
  logic signed [LT_W-1:0]   len_term_r;
  logic signed [34:0]       prod_hi_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [SCL_W-1:0]  scaled_r;
  logic signed [SUM_W-1:0]  total;
  logic signed [MT_W-1:0]   mt_r;

  always_comb begin
    quo_s    = $signed({2'b00, quo});
    rnd      = prod_r[PROD_W-1] ? 52'sd127 : 52'sd128;
    prod_rnd = prod_r + rnd;
    total    = SUM_W'(scaled_r) + SUM_W'(tm_offset_r) + SUM_W'(pyr_term_r)
             + SUM_W'(len_term_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start_p) begin
      raw_r <= (neg_h_r ? -quo_s : quo_s) - KELVIN_Q8;
    end
    if (cmd.mul_lo) begin
      pyr_term_r <= pc_neg_r ? -$signed({1'b0, quo[15:0]}) : $signed({1'b0, quo[15:0]});
      prod_lo_r  <= 33'(raw_r[16:0]) * 33'(tm_scale_r);
      len_term_r <= LT_W'(len_coeff_r) * LT_W'($signed({1'b0, len_fin_r}));
    end
    if (cmd.mul_hi) begin
      prod_hi_r <= 35'($signed(raw_r[RAW_W-1:17])) * 35'($signed({1'b0, tm_scale_r}));
    end
    if (cmd.scale) begin
      prod_r <= (PROD_W'(prod_hi_r) <<< 17) + $signed({19'b0, prod_lo_r});
    end
    if (cmd.round) begin
      scaled_r <= SCL_W'(prod_rnd >>> 8);
    end
    if (cmd.sum) begin
      if (total < MT_MIN) begin
        mt_r <= MT_MIN[MT_W-1:0];
      end else if (total > MT_MAX) begin
        mt_r <= MT_MAX[MT_W-1:0];
      end else begin
        mt_r <= total[MT_W-1:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_melt_temp        <= (too_long_r || fault_r) ? '0 : mt_r;
      out_enthalpy_total   <= h_acc_r;
      out_entropy_total    <= s_acc_r;
      out_pyrimidine_count <= CNT_OUT_W'(pyr_acc_r);
      out_seq_length       <= CNT_OUT_W'(len_fin_r);
      out_too_long         <= too_long_r;
      out_divide_fault     <= fault_r;
    end
  end

  assign sts.skip     = too_long_r || fault_r;
  assign sts.div_busy = div_busy;

endmodule

/* hw/rtl/pmt_ctrl.sv */
// Controller: sequences accumulation, the two divides and the result handoff.
module pmt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_is_last,
  output logic              in_stall,
  input  logic              out_stall,
  output logic              out_valid,
  output pmt_pkg::pmt_cmd_t cmd,
  input  pmt_pkg::pmt_sts_t sts
);
  import pmt_pkg::*;

  pmt_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;
  logic       out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    in_fire   = 1'b0;
    out_free  = !out_valid_r || !out_stall;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        in_fire    = in_valid;
        cmd.acc_en = in_fire;
        if (in_fire && in_is_last) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = ST_START_H;
      end
      ST_START_H: begin
        // faulted or overlong sequence: skip the divides and report zero Tm
        cmd.div_start_h = !sts.skip;
        state_nxt       = sts.skip ? ST_OUT : ST_WAIT_H;
      end
      ST_WAIT_H: begin
        if (!sts.div_busy) begin
          state_nxt = ST_START_P;
        end
      end
      ST_START_P: begin
        cmd.div_start_p = 1'b1;
        state_nxt       = ST_WAIT_P;
      end
      ST_WAIT_P: begin
        if (!sts.div_busy) begin
          state_nxt = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/pna_melting_temp_calc.sv */
// Top level of the streaming PNA nearest-neighbor melting temperature block.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  base_char[7:0], is_last
//   out_     output     out_valid/out_stall  melt_temp[16:0] s, enthalpy_total[21:0] s,
//                                            entropy_total[15:0] s, pyrimidine_count[10:0],
//                                            seq_length[10:0], too_long, divide_fault
//   cfg_     input      cfg_valid/cfg_ready  cfg_index[2:0], cfg_data[15:0]
//
// A base that is not last leaves the input unstalled; the next base is taken in the following cycle.
// The last base starts the Tm sequence: the check state, then two divides on the shared divider,
// each waited out until the divider is done, then the multiply, scale, round and sum states
// before the result register loads; an overlong or zero-divisor sequence skips the divides and the arithmetic.
// The result register lets new bases in while a result waits under out_stall; a second
// last base then holds in the handoff state until that result is taken.
// Synchronous active-low reset clears the sums and the controller and sets the configuration registers to defaults.
module pna_melting_temp_calc #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_base_char,
  input  logic                            in_is_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [pmt_pkg::MT_W-1:0] out_melt_temp,
  output logic signed [pmt_pkg::H_W-1:0]  out_enthalpy_total,
  output logic signed [pmt_pkg::S_W-1:0]  out_entropy_total,
  output logic [pmt_pkg::CNT_OUT_W-1:0]   out_pyrimidine_count,
  output logic [pmt_pkg::CNT_OUT_W-1:0]   out_seq_length,
  output logic                            out_too_long,
  output logic                            out_divide_fault,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pmt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pmt_pkg::*;

  pmt_cmd_t cmd;
  pmt_sts_t sts;

  assign cfg_ready = 1'b1;

  pmt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_last (in_is_last),
    .in_stall   (in_stall),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .cmd        (cmd),
    .sts        (sts)
  );

  pmt_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_base_char         (in_base_char),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_melt_temp        (out_melt_temp),
    .out_enthalpy_total   (out_enthalpy_total),
    .out_entropy_total    (out_entropy_total),
    .out_pyrimidine_count (out_pyrimidine_count),
    .out_seq_length       (out_seq_length),
    .out_too_long         (out_too_long),
    .out_divide_fault     (out_divide_fault)
  );

endmodule

/* hw/rtl/pmt_check.sv */
// Port-level checker for the melting temperature block and its bind.
module pmt_check #(
  parameter int unsigned MAX_LEN = 64
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            in_is_last,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [pmt_pkg::MT_W-1:0] out_melt_temp,
  input logic signed [pmt_pkg::H_W-1:0]  out_enthalpy_total,
  input logic signed [pmt_pkg::S_W-1:0]  out_entropy_total,
  input logic [pmt_pkg::CNT_OUT_W-1:0]   out_pyrimidine_count,
  input logic [pmt_pkg::CNT_OUT_W-1:0]   out_seq_length,
  input logic                            out_too_long,
  input logic                            out_divide_fault
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_melt_temp)
      && $stable(out_seq_length) && $stable(out_enthalpy_total)
      && $stable(out_entropy_total) && $stable(out_pyrimidine_count)
      && $stable(out_too_long) && $stable(out_divide_fault))
    else $error("result changed under stall");

  // a base that is not last never stalls the next one
  a_base_rate: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_is_last |=> !in_stall)
    else $error("input stalled after a non-final base");

  // the last base starts the Tm sequence
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_is_last |=> in_stall)
    else $error("input not stalled after a final base");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_seq_length != '0
      && out_seq_length <= pmt_pkg::CNT_OUT_W'(MAX_LEN))
    else $error("sequence length out of range");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_too_long || out_divide_fault) |-> out_melt_temp == '0)
    else $error("flagged result with nonzero Tm");

endmodule

bind pna_melting_temp_calc pmt_check #(.MAX_LEN(MAX_LEN)) u_pmt_check (.*);

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the PNA nearest-neighbor melting temperature block.
module tb;
  import pmt_pkg::*;

  localparam int SEQ_MAX     = 64;
  localparam int IDLE_MAX    = 17;
  localparam int TM_LATENCY  = 80;
  localparam int ITEM_TARGET = 1950;
  localparam int PHASE_ITEMS = 150;
  localparam int H_FLOOR     = -2097152;
  localparam int S_FLOOR     = -32768;
  localparam longint KELVIN_Q8_TB = 69926;
  localparam longint TM_LO = -65536;
  localparam longint TM_HI = 65535;

  // config selections for a phase
  localparam int CFG_PICK_RANDOM = 0;
  localparam int CFG_PICK_LOW    = 1;
  localparam int CFG_PICK_HIGH   = 2;

  typedef struct {
    logic signed [MT_W-1:0]  melt;
    logic signed [H_W-1:0]   dh;
    logic signed [S_W-1:0]   ds;
    logic [CNT_OUT_W-1:0]    pyr;
    logic [CNT_OUT_W-1:0]    len;
    logic                    too_long;
    logic                    fault;
  } tm_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [7:0]               in_base_char;
  logic                     in_is_last;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [MT_W-1:0]   out_melt_temp;
  logic signed [H_W-1:0]    out_enthalpy_total;
  logic signed [S_W-1:0]    out_entropy_total;
  logic [CNT_OUT_W-1:0]     out_pyrimidine_count;
  logic [CNT_OUT_W-1:0]     out_seq_length;
  logic                     out_too_long;
  logic                     out_divide_fault;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  // predictor state and register copies
  logic [2:0]               nn_prev;
  int                       nn_dh_sum;
  int                       nn_ds_sum;
  int                       nn_pyr;
  int                       nn_len;
  logic signed [11:0]       conc_m;
  logic [15:0]              scale_m;
  logic signed [15:0]       offset_m;
  logic signed [15:0]       pyr_coeff_m;
  logic signed [15:0]       len_coeff_m;

  tm_result_t               tm_results_q[$];

  int  mismatches;
  int  items_sent;
  int  seqs_sent;
  int  results_seen;
  int  too_long_seen;
  int  fault_seen;
  int  settings_used;
  int  rx_hold_cycles;
  bit  tx_no_idle;
  bit  rx_no_idle;

  pna_melting_temp_calc #(
    .MAX_LEN(SEQ_MAX)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_base_char         (in_base_char),
    .in_is_last           (in_is_last),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_melt_temp        (out_melt_temp),
    .out_enthalpy_total   (out_enthalpy_total),
    .out_entropy_total    (out_entropy_total),
    .out_pyrimidine_count (out_pyrimidine_count),
    .out_seq_length       (out_seq_length),
    .out_too_long         (out_too_long),
    .out_divide_fault     (out_divide_fault),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [2:0] char_to_code(input logic [7:0] c);
    case (c)
      "A", "a": return CODE_A;
      "C", "c": return CODE_C;
      "G", "g": return CODE_G;
      "T", "t": return CODE_T;
      default:  return CODE_NONE;
    endcase
  endfunction

  // stacking enthalpy, cal/mol, indexed {first, second}
  function automatic int pair_dh(input logic [3:0] k);
    case (k)
      4'd0:  return -8400;
      4'd1:  return -8600;
      4'd2:  return -6100;
      4'd3:  return -6500;
      4'd4:  return -7400;
      4'd5:  return -6700;
      4'd6:  return -10100;
      4'd7:  return -6100;
      4'd8:  return -7700;
      4'd9:  return -11100;
      4'd10: return -6700;
      4'd11: return -8600;
      4'd12: return -6300;
      4'd13: return -7700;
      4'd14: return -7400;
      default: return -8400;
    endcase
  endfunction

  // stacking entropy, tenths of cal/K/mol
  function automatic int pair_ds(input logic [3:0] k);
    case (k)
      4'd0:  return -236;
      4'd1:  return -230;
      4'd2:  return -161;
      4'd3:  return -188;
      4'd4:  return -193;
      4'd5:  return -156;
      4'd6:  return -255;
      4'd7:  return -161;
      4'd8:  return -203;
      4'd9:  return -284;
      4'd10: return -156;
      4'd11: return -230;
      4'd12: return -185;
      4'd13: return -203;
      4'd14: return -193;
      default: return -236;
    endcase
  endfunction

  // divide, rounding to nearest with halves away from zero
  function automatic longint round_div(input longint n, input longint d);
    longint un;
    longint ud;
    longint q;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    if (ud == 0) return 0;
    q = (un + ud / 2) / ud;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic void clear_sums();
    nn_prev   = CODE_NONE;
    nn_dh_sum = 0;
    nn_ds_sum = 0;
    nn_pyr    = 0;
    nn_len    = 0;
  endfunction

  // Advance the predictor by one base; queue a Tm result on the last one.
  function automatic void nn_tm_step(input logic [7:0] ch, input bit last);
    logic [2:0] code;
    int         h;
    int         s;
    int         len;
    bit         over;
    bit         fault;
    longint     denom;
    longint     raw;
    longint     mt;
    tm_result_t r;
    code = char_to_code(ch);
    if (nn_len < SEQ_MAX) begin
      if (nn_prev != CODE_NONE && code != CODE_NONE) begin
        h = nn_dh_sum + pair_dh({nn_prev[1:0], code[1:0]});
        s = nn_ds_sum + pair_ds({nn_prev[1:0], code[1:0]});
        nn_dh_sum = (h < H_FLOOR) ? H_FLOOR : h;
        nn_ds_sum = (s < S_FLOOR) ? S_FLOOR : s;
      end
      if (code == CODE_C || code == CODE_T) nn_pyr++;
      nn_prev = code;
      nn_len++;
    end else begin
      nn_len = SEQ_MAX + 1;
    end
    if (last) begin
      over  = (nn_len > SEQ_MAX);
      len   = over ? SEQ_MAX : nn_len;
      denom = longint'(nn_ds_sum) + longint'(conc_m);
      fault = (denom == 0);
      mt    = 0;
      if (!over && !fault) begin
        raw = round_div(longint'(nn_dh_sum) * 2560, denom) - KELVIN_Q8_TB;
        mt  = round_div(raw * longint'(scale_m), 256);
        mt += longint'(offset_m);
        mt += round_div(longint'(pyr_coeff_m) * nn_pyr, len);
        mt += longint'(len_coeff_m) * len;
        if (mt < TM_LO) mt = TM_LO;
        if (mt > TM_HI) mt = TM_HI;
      end
      r.melt     = mt[MT_W-1:0];
      r.dh       = H_W'(nn_dh_sum);
      r.ds       = S_W'(nn_ds_sum);
      r.pyr      = CNT_OUT_W'(nn_pyr);
      r.len      = CNT_OUT_W'(len);
      r.too_long = over;
      r.fault    = fault;
      tm_results_q.push_back(r);
      clear_sums();
    end
  endfunction

  task automatic cmp_field(input string name, input logic signed [63:0] want,
                           input logic signed [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s in result %0d: expected %0d, got %0d",
                 name, results_seen, want, got);
    end
  endtask

  task automatic check_result();
    tm_result_t r;
    if (tm_results_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result %0d arrived with none pending", results_seen);
    end else begin
      r = tm_results_q.pop_front();
      cmp_field("melt_temp", 64'(r.melt), 64'(out_melt_temp));
      cmp_field("enthalpy_total", 64'(r.dh), 64'(out_enthalpy_total));
      cmp_field("entropy_total", 64'(r.ds), 64'(out_entropy_total));
      cmp_field("pyrimidine_count", 64'(r.pyr), 64'(out_pyrimidine_count));
      cmp_field("seq_length", 64'(r.len), 64'(out_seq_length));
      cmp_field("too_long", 64'(r.too_long), 64'(out_too_long));
      cmp_field("divide_fault", 64'(r.fault), 64'(out_divide_fault));
      if (r.too_long) too_long_seen++;
      if (r.fault) fault_seen++;
    end
    results_seen++;
  endtask

  // result side: random stall per item, optional long hold
  initial begin : result_sink
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = rx_no_idle ? 0 : $urandom_range(0, IDLE_MAX);
      end
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid && rx_hold_cycles == 0);
      if (out_valid) check_result();
      @(negedge clk);
    end
  end

  task automatic send_base(input logic [7:0] ch, input bit last);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    @(negedge clk);
    if (gap > 0) begin
      in_valid     = 1'b0;
      in_base_char = 8'($urandom);
      in_is_last   = 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_base_char = ch;
    in_is_last   = last;
    do @(posedge clk); while (in_stall);
    nn_tm_step(ch, last);
    items_sent++;
    if (last) seqs_sent++;
  endtask

  task automatic send_string(input string pat);
    for (int i = 0; i < pat.len(); i++) send_base(pat[i], i == pat.len() - 1);
  endtask

  function automatic logic [7:0] pick_base(input int noise_pct);
    if ($urandom_range(0, 99) < noise_pct) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: return "A";
      1: return "C";
      2: return "G";
      3: return "T";
      4: return "a";
      5: return "c";
      6: return "g";
      default: return "t";
    endcase
  endfunction

  // mostly short sequences, some right at and past the length limit
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 16);
    if (r < 90) return $urandom_range(17, SEQ_MAX - 1);
    if (r < 94) return SEQ_MAX;
    return $urandom_range(SEQ_MAX + 1, SEQ_MAX + 8);
  endfunction

  task automatic send_sequence(input int len, input int noise_pct);
    for (int i = 0; i < len; i++) send_base(pick_base(noise_pct), i == len - 1);
  endtask

  // Write one register; only called while the block is idle.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CONC:   conc_m      = data[11:0];
      CFG_SCALE:  scale_m     = data;
      CFG_OFFSET: offset_m    = data;
      CFG_PYR:    pyr_coeff_m = data;
      CFG_LEN:    len_coeff_m = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stop sending, let all pending results drain, then let the block settle.
  task automatic wait_idle(input int settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (tm_results_q.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_signed16(input int sel);
    int          r;
    logic [15:0] v;
    r = $urandom_range(0, 9);
    if (sel == CFG_PICK_LOW || (sel == CFG_PICK_RANDOM && r == 0)) return 16'h8000;
    if (sel == CFG_PICK_HIGH || (sel == CFG_PICK_RANDOM && r == 1)) return 16'h7fff;
    if (r < 7) v = 16'($urandom_range(0, 4095) - 2048);
    else v = 16'($urandom);
    return v;
  endfunction

  task automatic load_config(input int sel);
    int          r;
    logic [15:0] v;
    logic [15:0] junk;
    r    = $urandom_range(0, 9);
    junk = 16'($urandom);
    if (sel == CFG_PICK_LOW) v = -16'sd2048;
    else if (sel == CFG_PICK_HIGH) v = 16'd2047;
    else if (r == 0) v = -16'sd2000;
    else if (r == 1) v = 16'd2000;
    else v = 16'($urandom_range(0, 4000) - 2000);
    // upper bits above the 12-bit field are don't-care
    cfg_write(CFG_CONC, {junk[15:12], v[11:0]});
    r = $urandom_range(0, 9);
    if (sel == CFG_PICK_LOW || (sel == CFG_PICK_RANDOM && r == 0)) v = 16'h0000;
    else if (sel == CFG_PICK_HIGH || (sel == CFG_PICK_RANDOM && r == 1)) v = 16'hffff;
    else if (r < 7) v = 16'($urandom_range(64, 512));
    else v = 16'($urandom);
    cfg_write(CFG_SCALE, v);
    cfg_write(CFG_OFFSET, pick_signed16(sel));
    cfg_write(CFG_PYR, pick_signed16(sel));
    cfg_write(CFG_LEN, pick_signed16(sel));
    settings_used++;
  endtask

  // every stacking pair once, mixed case, plus the shortest sequence
  task automatic test_directed_pairs();
    send_string("AaCaGaTcCgCtGgTtA");
    send_base("A", 1'b1);
  endtask

  // ambiguous bytes break pairs but still count as length
  task automatic test_ambiguous();
    wait_idle(TM_LATENCY);
    cfg_write(CFG_PYR, 16'd1280);
    cfg_write(CFG_LEN, -16'sd64);
    send_base("C", 1'b0);
    send_base(8'h00, 1'b0);
    send_base("g", 1'b0);
    send_base(8'hff, 1'b0);
    send_base("T", 1'b1);
  endtask

  task automatic test_zero_divisor();
    wait_idle(TM_LATENCY);
    cfg_write(CFG_CONC, 16'd0);
    send_base("G", 1'b1);
    wait_idle(TM_LATENCY);
    // cancels the A-A stack entropy exactly
    cfg_write(CFG_CONC, 16'd236);
    send_string("Aa");
  endtask

  // hold the result side while bases keep coming, so the block backs up
  task automatic test_backpressure();
    wait_idle(TM_LATENCY);
    load_config(CFG_PICK_RANDOM);
    tx_no_idle     = 1'b1;
    rx_hold_cycles = 300;
    repeat (6) send_sequence(3, 0);
    tx_no_idle = 1'b0;
    wait_idle(TM_LATENCY);
  endtask

  task automatic test_random_sequences();
    int phase;
    int phase_items;
    int len;
    int noise;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle(TM_LATENCY);
      if (phase == 0) load_config(CFG_PICK_LOW);
      else if (phase == 1) load_config(CFG_PICK_HIGH);
      else load_config(CFG_PICK_RANDOM);
      tx_no_idle  = ($urandom_range(0, 4) == 0);
      rx_no_idle  = ($urandom_range(0, 4) == 0);
      noise       = $urandom_range(0, 15);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS && items_sent < ITEM_TARGET) begin
        len = pick_length();
        send_sequence(len, noise);
        phase_items += len;
      end
      phase++;
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_base_char   = 8'h00;
    in_is_last     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_CONC;
    cfg_data       = 16'h0000;
    mismatches     = 0;
    items_sent     = 0;
    seqs_sent      = 0;
    results_seen   = 0;
    too_long_seen  = 0;
    fault_seen     = 0;
    settings_used  = 0;
    rx_hold_cycles = 0;
    tx_no_idle     = 1'b0;
    rx_no_idle     = 1'b0;
    conc_m         = CONC_RESET;
    scale_m        = SCALE_RESET;
    offset_m       = '0;
    pyr_coeff_m    = '0;
    len_coeff_m    = '0;
    clear_sums();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_directed_pairs();
    test_ambiguous();
    test_zero_divisor();
    test_backpressure();
    test_random_sequences();

    wait_idle(TM_LATENCY);
    $display("summary: %0d bases in %0d sequences, %0d results over %0d register settings",
             items_sent, seqs_sent, results_seen, settings_used);
    $display("summary: %0d over-length and %0d zero-divisor results, %0d mismatches",
             too_long_seen, fault_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
